// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) (prop)) \
        else $error(msg);

// Assertion on the usual clk / rst_n pair of the module.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, clk, rst_n, prop, msg)

`else

`define ASSERT_CLK(label, clock, reset_n, prop, msg)
`define ASSERT_STD(label, prop, msg)

`endif

`endif

// File: rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Types and constants of the pulse-skip triac modulator.
// ----------------------------------------------------------------------------
package ptm_pkg;

    localparam int unsigned LEVEL_W   = 16;
    localparam int unsigned DIV_W     = 8;
    localparam int unsigned GAP_W     = 26;
    localparam int unsigned STOP_W    = 31;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned ACC_W     = LEVEL_W + 1;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [LEVEL_W-1:0] FULL_SCALE_RST = LEVEL_W'(100);
    localparam logic [DIV_W-1:0]   DIVIDER_RST    = DIV_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_SCALE = 2'd0,
        REG_EVENT_DIV  = 2'd1,
        REG_MIN_GAP    = 2'd2,
        REG_STOP_LIMIT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  event_time;
        logic [LEVEL_W-1:0] drive_level;
        logic               clear_count;
    } evt_word_t;

    typedef struct packed {
        logic               triac_on;
        logic               event_accepted;
        logic [COUNT_W-1:0] pulse_count;
    } res_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DAT_W-1:0] reg_data;
    } cfg_word_t;

endpackage

// File: rtl/ptm_stream_if.sv
// ----------------------------------------------------------------------------
// ptm_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ptm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/pulse_skip_triac_modulator_core.sv
// ----------------------------------------------------------------------------
// pulse_skip_triac_modulator_core
// Pulse-density triac modulator stepped by mains zero-cross events.
// ----------------------------------------------------------------------------
// Takes one zero-cross word per clock, unless the output stalls, and returns
// one result word for each, in order. A word sits in an input register, the
// whole modulator update (debounce, divider, clamp/accumulate/reduce,
// saturating pulse count, stop limit) runs in one combinational pass, and the
// result lands in a result register; throughput is one word per cycle while
// res.ready is high. The input register and the result register form a
// two-word buffer, so a new event is taken while a finished result still
// waits on the output. Configuration writes are taken every cycle (cfg.ready
// is always high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_skip_triac_modulator_core (
    input logic        clk,
    input logic        rst_n,
    ptm_stream_if.sink   evt,
    ptm_stream_if.source res,
    ptm_stream_if.sink   cfg
);
    import ptm_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0] full_scale_reg;
    logic [DIV_W-1:0]   divider_reg;
    logic [GAP_W-1:0]   min_gap_reg;
    logic [STOP_W-1:0]  stop_limit_reg;

    // modulator state
    logic [TIME_W-1:0]  last_time_reg,  last_time_next;
    logic [DIV_W-1:0]   phase_reg,      phase_next;
    logic [ACC_W-1:0]   acc_reg,        acc_next;
    logic               skip_reg,       skip_next;
    logic [COUNT_W-1:0] count_reg,      count_next;

    // pipeline
    logic      in_vld_reg;
    evt_word_t in_word_reg;
    logic      res_vld_reg;
    res_word_t res_word_reg;
    res_word_t res_word_next;

    logic advance;
    logic step;

    // working values of the update
    logic [LEVEL_W-1:0] range_w;
    logic [DIV_W-1:0]   div_w;
    logic [TIME_W-1:0]  elapsed;
    logic               accepted;
    logic               update;
    logic [LEVEL_W-1:0] level_c;
    logic [ACC_W-1:0]   range_x;
    logic [ACC_W-1:0]   sum;
    logic [ACC_W-1:0]   reduced;
    logic               fire;
    logic [COUNT_W-1:0] count_base;
    logic [COUNT_W-1:0] count_fired;

    assign advance   = !res_vld_reg || res.ready;
    assign step      = in_vld_reg && advance;
    assign evt.ready = !in_vld_reg || advance;
    assign cfg.ready = 1'b1;
    assign res.valid   = res_vld_reg;
    assign res.payload = res_word_reg;

    // ---- configuration port ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FULL_SCALE_RST;
            divider_reg    <= DIVIDER_RST;
            min_gap_reg    <= '0;
            stop_limit_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.payload.reg_index))
                REG_FULL_SCALE: full_scale_reg <= cfg.payload.reg_data[LEVEL_W-1:0];
                REG_EVENT_DIV:  divider_reg    <= cfg.payload.reg_data[DIV_W-1:0];
                REG_MIN_GAP:    min_gap_reg    <= cfg.payload.reg_data[GAP_W-1:0];
                REG_STOP_LIMIT: stop_limit_reg <= cfg.payload.reg_data[STOP_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---- single-pass modulator update ----
    always_comb
    begin
        // zero modulus / divider behave as one
        range_w = (full_scale_reg == '0) ? LEVEL_W'(1) : full_scale_reg;
        div_w   = (divider_reg == '0) ? DIV_W'(1) : divider_reg;
        range_x = {1'b0, range_w};

        // a clear request applies even to a rejected event
        count_base = in_word_reg.clear_count ? '0 : count_reg;

        // debounce with wrapping difference; gap of zero accepts everything
        elapsed  = in_word_reg.event_time - last_time_reg;
        accepted = (min_gap_reg == '0) ||
                   (elapsed >= {{(TIME_W-GAP_W){1'b0}}, min_gap_reg});
        update   = accepted && (phase_reg >= (div_w - DIV_W'(1)));

        level_c = (in_word_reg.drive_level > range_w) ? range_w : in_word_reg.drive_level;
        sum     = acc_reg + {1'b0, level_c};
        if (sum >= range_x)
        begin
            reduced = sum - range_x;
            fire    = 1'b1;
        end
        else
        begin
            reduced = sum;
            fire    = 1'b0;
        end
        // stray value left over after full_scale was lowered
        if (reduced > range_x)
        begin
            reduced = '0;
            fire    = 1'b1;
        end

        count_fired = (count_base == '1) ? count_base : count_base + COUNT_W'(1);

        last_time_next = last_time_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        skip_next      = skip_reg;
        count_next     = count_base;

        if (accepted && (min_gap_reg != '0))
            last_time_next = in_word_reg.event_time;

        if (update)
        begin
            phase_next = '0;
            acc_next   = reduced;
            if (fire)
            begin
                count_next = count_fired;
                skip_next  = (stop_limit_reg != '0) &&
                             (count_fired > {1'b0, stop_limit_reg});
            end
            else
                skip_next = 1'b1;
        end
        else if (accepted)
            phase_next = phase_reg + DIV_W'(1);

        res_word_next.triac_on       = !skip_next;
        res_word_next.event_accepted = accepted;
        res_word_next.pulse_count    = count_next;
    end

    // ---- state and pipeline control ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            phase_reg     <= '0;
            acc_reg       <= '0;
            skip_reg      <= 1'b1;
            count_reg     <= '0;
            in_vld_reg    <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                last_time_reg <= last_time_next;
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                skip_reg      <= skip_next;
                count_reg     <= count_next;
            end
            if (evt.ready)
                in_vld_reg <= evt.valid;
            if (advance)
                res_vld_reg <= in_vld_reg;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
            in_word_reg <= evt.payload;
        if (step)
            res_word_reg <= res_word_next;
    end

    // ---- assertions ----
    `ASSERT_STD(a_acc_in_range, acc_reg[ACC_W-1] == 1'b0, "accumulator left 16-bit range")
    `ASSERT_STD(a_hold_on_stall, (in_vld_reg && !advance) |=> in_vld_reg, "queued event lost")
    `ASSERT_STD(a_reject_keeps_phase, (step && !accepted) |=> $stable(phase_reg), "rejected event moved divider")

endmodule

// File: tb/pulse_skip_triac_modulator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_skip_triac_modulator_core_tb
// Self-checking bench for the zero-cross driven pulse-skip modulator. A
// bit-true predictor runs on every accepted event word and each result word
// is compared field by field in order. Directed cases cover the corners
// first: clamping, zero registers, stray accumulator, divider lowering,
// debounce with wrap, and the stop limit. Random traffic follows under
// varied register settings and handshake idling, with one long output stall.
// ----------------------------------------------------------------------------
module pulse_skip_triac_modulator_core_tb;
    import ptm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000; // watchdog, far above the slowest legal run
    localparam int SETTLE_CYCLES = 4;      // pipeline settling margin after the queue drains
    localparam int HOLD_CYCLES   = 300;    // long output stall for the fill-up test
    localparam int RAND_BLOCKS   = 6;      // register settings per idling mode
    localparam int BLOCK_WORDS   = 105;    // event words per setting

    logic clk = 1'b0;
    logic rst_n;

    ptm_stream_if #(.payload_t(evt_word_t)) evt_if ();
    ptm_stream_if #(.payload_t(res_word_t)) res_if ();
    ptm_stream_if #(.payload_t(cfg_word_t)) cfg_if ();

    pulse_skip_triac_modulator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor copy of the registers and modulator state
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] mdl_full_scale = FULL_SCALE_RST;
    logic [DIV_W-1:0]   mdl_divider    = DIVIDER_RST;
    logic [GAP_W-1:0]   mdl_min_gap    = '0;
    logic [STOP_W-1:0]  mdl_stop_limit = '0;

    logic [TIME_W-1:0]  mdl_last_time  = '0;
    logic [DIV_W-1:0]   mdl_phase      = '0;
    logic [ACC_W-1:0]   mdl_acc        = '0;
    logic               mdl_skip       = 1'b1;   // triac off out of reset
    logic [COUNT_W-1:0] mdl_fired      = '0;

    res_word_t expected_results[$];   // one per accepted event word, oldest first

    // stimulus-side view of the settings, used to shape event timing and levels
    int unsigned cur_full_scale = 100;
    int unsigned cur_min_gap    = 0;
    logic [TIME_W-1:0] mains_time = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_kick     = 1'b0;

    int mismatch_count = 0;
    int n_events       = 0;
    int n_rejected     = 0;
    int n_pulses       = 0;
    int n_writes       = 0;
    int cycle_count    = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void store_register(input cfg_word_t c);
        case (cfg_reg_t'(c.reg_index))
            REG_FULL_SCALE: mdl_full_scale = c.reg_data[LEVEL_W-1:0];
            REG_EVENT_DIV:  mdl_divider    = c.reg_data[DIV_W-1:0];
            REG_MIN_GAP:    mdl_min_gap    = c.reg_data[GAP_W-1:0];
            REG_STOP_LIMIT: mdl_stop_limit = c.reg_data[STOP_W-1:0];
            default: ;
        endcase
    endfunction

    // One zero-cross event: debounce, divider, clamp/accumulate/reduce,
    // saturating pulse count, stop limit.
    function automatic res_word_t model_zero_cross(input evt_word_t w);
        int unsigned range_v;
        int unsigned div_v;
        int unsigned lvl;
        int unsigned acc;
        logic [TIME_W-1:0] since;
        logic accepted;
        res_word_t r;
        range_v  = (mdl_full_scale == 0) ? 1 : mdl_full_scale;  // zero scale acts as 1
        div_v    = (mdl_divider == 0) ? 1 : mdl_divider;        // zero divider acts as 1
        accepted = 1'b1;
        if (w.clear_count)
            mdl_fired = '0;                      // clear applies even on a rejected event
        if (mdl_min_gap != 0)
        begin
            since = w.event_time - mdl_last_time;    // wraps modulo 2^32
            if (since < mdl_min_gap)
                accepted = 1'b0;
            else
                mdl_last_time = w.event_time;
        end
        if (accepted)
        begin
            if (mdl_phase >= div_v - 1)
            begin
                mdl_phase = '0;
                lvl = (w.drive_level > range_v) ? range_v : w.drive_level;
                acc = mdl_acc + lvl;
                if (acc >= range_v)
                begin
                    acc = acc - range_v;
                    mdl_skip = 1'b0;
                end
                else
                    mdl_skip = 1'b1;
                if (acc > range_v)
                begin
                    // leftover above a lowered scale: dump it and fire
                    acc = 0;
                    mdl_skip = 1'b0;
                end
                mdl_acc = ACC_W'(acc);
                if (!mdl_skip)
                begin
                    if (mdl_fired != '1)
                        mdl_fired = mdl_fired + 1'b1;
                    if (mdl_stop_limit != 0 && mdl_fired > mdl_stop_limit)
                        mdl_skip = 1'b1;
                end
            end
            else
                mdl_phase = mdl_phase + 1'b1;
        end
        r.triac_on       = ~mdl_skip;
        r.event_accepted = accepted;
        r.pulse_count    = mdl_fired;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result(input res_word_t got);
        res_word_t want;
        if (got.event_accepted == 1'b0)
            n_rejected++;
        if (got.triac_on)
            n_pulses++;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result word %h with nothing expected", got));
            return;
        end
        want = expected_results.pop_front();
        if (got.triac_on !== want.triac_on)
            report_mismatch($sformatf("triac_on exp %b got %b",
                                      want.triac_on, got.triac_on));
        if (got.event_accepted !== want.event_accepted)
            report_mismatch($sformatf("event_accepted exp %b got %b",
                                      want.event_accepted, got.event_accepted));
        if (got.pulse_count !== want.pulse_count)
            report_mismatch($sformatf("pulse_count exp %0d got %0d",
                                      want.pulse_count, got.pulse_count));
    endtask

    // All handshakes sampled at the rising edge, before any NBA update of
    // this step lands, so the bench sees what the block saw. The predictor
    // runs before the result pop; queue order keeps this safe either way.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                store_register(cfg_if.payload);
                n_writes++;
            end
            if (evt_if.valid && evt_if.ready)
            begin
                expected_results.push_back(model_zero_cross(evt_if.payload));
                n_events++;
            end
            if (res_if.valid && res_if.ready)
                check_result(res_if.payload);
        end
    end

    // ------------------------------------------------------------------
    // Result side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_kick != hold_seen)
            begin
                hold_seen = hold_kick;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one event word; returns right after the edge that took it,
    // with valid still high so back-to-back words need no re-raise.
    task automatic send_event(input evt_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_if.valid <= 1'b0;
            @(posedge clk);
        end
        evt_if.valid   <= 1'b1;
        evt_if.payload <= w;
        do @(posedge clk); while (!evt_if.ready);
    endtask

    task automatic send_at(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] lvl,
                           input logic clr);
        evt_word_t w;
        w.event_time  = t;
        w.drive_level = lvl;
        w.clear_count = clr;
        send_event(w);
    endtask

    // Drop valid, step to the sampling edge so the monitor has queued the last word,
    // let every expected word drain, then cover the pipeline.
    task automatic wait_idle();
        evt_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_register(input cfg_reg_t r, input logic [CFG_DAT_W-1:0] d);
        cfg_word_t c;
        c.reg_index = r;
        c.reg_data  = d;
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= c;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    // Writes all four registers back to back while the block is idle.
    task automatic apply_settings(input int unsigned fs, input int unsigned div,
                                  input int unsigned gap, input int unsigned stop);
        wait_idle();
        put_register(REG_FULL_SCALE, fs);
        put_register(REG_EVENT_DIV, div);
        put_register(REG_MIN_GAP, gap);
        put_register(REG_STOP_LIMIT, stop);
        cfg_if.valid <= 1'b0;
        cur_full_scale = fs;
        cur_min_gap    = gap;
    endtask

    // Mostly mains-like timing around the debounce gap, some noise stamps.
    function automatic evt_word_t make_event();
        evt_word_t w;
        int unsigned pick;
        int unsigned fs_eff;
        int unsigned lvl;
        fs_eff = (cur_full_scale == 0) ? 1 : cur_full_scale;
        pick = $urandom_range(99);
        if (cur_min_gap == 0 || pick < 8)
            mains_time = $urandom();
        else if (pick < 12)
            mains_time = mains_time + cur_min_gap;         // exactly on the gap
        else if (pick < 16)
            mains_time = mains_time + cur_min_gap - 1;     // one short
        else
            mains_time = mains_time + $urandom_range(2 * cur_min_gap);
        pick = $urandom_range(99);
        if (pick < 55)
            lvl = $urandom_range(fs_eff, 0);
        else if (pick < 75)
            lvl = $urandom_range(65535);
        else if (pick < 85)
            lvl = 0;
        else if (pick < 92)
            lvl = 65535;
        else
            lvl = fs_eff;
        w.event_time  = mains_time;
        w.drive_level = LEVEL_W'(lvl);
        w.clear_count = ($urandom_range(99) < 4);
        return w;
    endfunction

    task automatic random_settings(input int blk);
        int unsigned fs, div, gap, stop;
        case ($urandom_range(5))
            0:       fs = 1;
            1:       fs = 65535;
            2, 3:    fs = $urandom_range(200, 1);
            default: fs = $urandom_range(65535, 1);
        endcase
        case ($urandom_range(19))
            0:       div = 0;
            1:       div = 255;
            2, 3, 4, 5, 6, 7: div = $urandom_range(6, 2);
            default: div = 1;
        endcase
        case ($urandom_range(9))
            0, 1, 2: gap = 0;
            3:       gap = 61200000;
            default: gap = $urandom_range(2000000, 1);
        endcase
        case ($urandom_range(9))
            0:          stop = 2147483647;
            1, 2, 3, 4: stop = $urandom_range(60, 1);
            default:    stop = 0;
        endcase
        // first two settings of each mode pin the register extremes
        if (blk == 0)
        begin
            fs = 65535; div = 1; gap = 61200000; stop = 2147483647;
        end
        else if (blk == 1)
        begin
            fs = 1; div = 1; gap = 0; stop = 1;
        end
        apply_settings(fs, div, gap, stop);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset defaults: scale 100, every event updates, no debounce, no stop.
    task automatic test_reset_state();
        send_at(32'h0000_0000, 16'd0, 1'b0);
        send_at(32'hFFFF_FFFF, 16'hFFFF, 1'b0);   // clamps to 100, fires
        send_at(32'h0000_0001, 16'd50, 1'b0);
        send_at(32'h0000_0002, 16'd50, 1'b1);     // clear, then fires
    endtask

    // Zero scale and zero divider act as 1; widest scale.
    task automatic test_clamp_and_scale();
        apply_settings(0, 0, 0, 0);
        send_at(32'd10, 16'd0, 1'b0);
        send_at(32'd11, 16'hFFFF, 1'b0);
        apply_settings(65535, 1, 0, 0);
        send_at(32'd12, 16'd32768, 1'b0);
        send_at(32'd13, 16'd32767, 1'b0);          // reaches full scale exactly
    endtask

    // Leftover above a lowered scale is dumped and the pulse fires.
    task automatic test_stray_accumulator();
        apply_settings(1000, 1, 0, 0);
        send_at(32'd20, 16'd900, 1'b0);
        apply_settings(300, 1, 0, 0);
        send_at(32'd21, 16'd0, 1'b0);
    endtask

    // Phase already past a lowered divider: next event updates.
    task automatic test_divider_lowered();
        apply_settings(100, 5, 0, 0);
        send_at(32'd30, 16'd100, 1'b0);
        send_at(32'd31, 16'd100, 1'b0);
        send_at(32'd32, 16'd100, 1'b0);
        apply_settings(100, 2, 0, 0);
        send_at(32'd33, 16'd100, 1'b0);
        apply_settings(100, 255, 0, 0);
        send_at(32'd34, 16'd100, 1'b0);
    endtask

    // Debounce edges, clear on a rejected event, wrap, stop limit.
    task automatic test_debounce_and_stop();
        apply_settings(1, 1, 1000, 2);
        send_at(32'd5000, 16'd1, 1'b0);
        send_at(32'd5500, 16'd1, 1'b0);            // too close
        send_at(32'd5999, 16'd1, 1'b1);            // too close, still clears
        send_at(32'd6000, 16'd1, 1'b0);            // exactly on the gap
        send_at(32'd7000, 16'd1, 1'b0);
        send_at(32'd8000, 16'd1, 1'b0);            // count 3 > 2, suppressed
        send_at(32'hFFFF_FC00, 16'd1, 1'b0);
        send_at(32'h0000_0100, 16'd1, 1'b0);       // across the wrap
        apply_settings(1, 1, 61200000, 2147483647);
        send_at(32'd0, 16'd1, 1'b1);
        send_at(32'd61199999, 16'd1, 1'b0);
        send_at(32'd61200000, 16'd1, 1'b0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int blk = 0; blk < RAND_BLOCKS; blk++)
        begin
            random_settings(blk);
            for (int i = 0; i < BLOCK_WORDS; i++)
                send_event(make_event());
        end
    endtask

    // Output held off for a long stretch while words keep coming: the
    // two-word buffer fills and the input must stall without loss.
    task automatic test_backpressure();
        send_idle_pct = 0;
        random_settings(2);
        hold_kick = ~hold_kick;
        for (int i = 0; i < 40; i++)
            send_event(make_event());
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        evt_if.valid   <= 1'b0;
        evt_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_clamp_and_scale();
        test_stray_accumulator();
        test_divider_lowered();
        test_debounce_and_stop();
        test_random_traffic(24, 72);
        test_backpressure();
        test_random_traffic(72, 24);
        test_random_traffic(0, 0);

        wait_idle();
        $display("Ran %0d zero-cross words (%0d inside the debounce gap), %0d gate pulses,",
                 n_events, n_rejected, n_pulses);
        $display("%0d register writes, %0d mismatches.", n_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ptm_pkg.sv
rtl/ptm_stream_if.sv
rtl/pulse_skip_triac_modulator_core.sv
tb/pulse_skip_triac_modulator_core_tb.sv
